/* src/dmpp_pkg.sv */
// Shared types, constants and the arctangent table for the motor pair panning block.
package dmpp_pkg;

	// CORDIC datapath widths: inputs scaled by 2^8 plus gain headroom, angle in degrees Q16
	localparam int XW = 27;
	localparam int ZW = 25;
	localparam int UW = 24;

	localparam logic signed [ZW-1:0] DEG90_Q16 = 25'sd5898240;

	// position = floor(u * (MOTOR_COUNT-1) / 46080), 46080 = 1024 * 45
	localparam int DIV_PRE = 10;
	localparam int RECIP_W = 21;
	localparam int RSHIFT = 26;
	localparam logic [RECIP_W-1:0] RECIP45 = 21'd1491309;  // ceil(2^26 / 45)

	typedef struct packed {
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
	} in_t;

	typedef struct packed {
		logic [2:0] first_motor;
		logic [7:0] first_level;
		logic [2:0] second_motor;
		logic [7:0] second_level;
		logic       single_target;
	} out_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 25'sd2949120;
			1: v = 25'sd1740967;
			2: v = 25'sd919879;
			3: v = 25'sd466945;
			4: v = 25'sd234379;
			5: v = 25'sd117304;
			6: v = 25'sd58666;
			7: v = 25'sd29335;
			8: v = 25'sd14668;
			9: v = 25'sd7334;
			10: v = 25'sd3667;
			11: v = 25'sd1833;
			12: v = 25'sd917;
			13: v = 25'sd458;
			14: v = 25'sd229;
			15: v = 25'sd115;
			16: v = 25'sd57;
			17: v = 25'sd29;
			18: v = 25'sd14;
			19: v = 25'sd7;
			20: v = 25'sd4;
			21: v = 25'sd2;
			22: v = 25'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* src/direction_to_motor_pair_panning.sv */
// Direction vector to motor pair panning: CORDIC angle, linear map, level split.
//
// Takes one (vec_x, vec_y) request per cycle unless stalled, returning one result per request,
// in order. The pipeline is an entry stage, one stage per CORDIC rotation, then clamp, scale
// multiply, reciprocal multiply and level multiply stages. Throughput is one request per cycle
// while in_ready is high, set by the fully pipelined rotation chain; a two-deep output (final
// stage plus skid register) keeps in_ready registered and absorbs one result on output stall.
// max_level resets to 255 and should be written only while the block is empty.
module direction_to_motor_pair_panning #(
	parameter int MOTOR_COUNT  = 8,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dmpp_pkg::in_t        in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dmpp_pkg::out_t       out_data,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata
);
	import dmpp_pkg::*;

	localparam int N   = CORDIC_STEPS;
	localparam int CW  = $clog2(MOTOR_COUNT);
	localparam int MW  = UW + CW;
	localparam int WW  = MW - DIV_PRE;
	localparam int PRW = WW + RECIP_W;
	localparam int PW  = $clog2((MOTOR_COUNT - 1) * 256 + 1);
	localparam int IW  = PW - 8;

	logic en;
	logic [7:0] max_level_q;

	// CORDIC chain, index 0 is the entry stage
	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic                 byp_s [N+1];
	logic                 vld_s [N+1];

	logic [UW-1:0]  u_s1;
	logic [MW-1:0]  m_s2;
	logic [PRW-1:0] p_s3;
	out_t           out_s4;
	logic           vld_s1, vld_s2, vld_s3, vld_s4;

	out_t skid_q;
	logic skid_full_q;

	assign en = ~skid_full_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q <= 8'd255;
		end else if (cfg_we) begin
			max_level_q <= cfg_wdata;
		end
	end

	// entry: special directions bypass the rotations with a fixed angle
	logic signed [XW-1:0] x_in, y_in;
	logic signed [ZW-1:0] z_in;
	logic                 byp_in;

	always_comb begin
		x_in = $signed({{(XW-24){in_data.vec_x[15]}}, in_data.vec_x, 8'h00});
		y_in = $signed({{(XW-24){in_data.vec_y[15]}}, in_data.vec_y, 8'h00});
		z_in = '0;
		byp_in = 1'b0;
		if (in_data.vec_x <= 16'sd0) begin
			byp_in = 1'b1;
			if (in_data.vec_y < 16'sd0)
				z_in = -DEG90_Q16;
			else if (in_data.vec_y == 16'sd0 && in_data.vec_x == 16'sd0)
				z_in = '0;
			else
				z_in = DEG90_Q16;
		end else if (in_data.vec_y == 16'sd0) begin
			byp_in = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= x_in;
			y_s[0]   <= y_in;
			z_s[0]   <= z_in;
			byp_s[0] <= byp_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [XW-1:0] xs, ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				byp_s[i+1] <= byp_s[i];
				if (byp_s[i]) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end else if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + atan_q16(i);
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - atan_q16(i);
				end
			end
		end
	end

	// clamp to +-90 degrees and offset to 0..180
	logic signed [ZW-1:0] z_cl;
	logic signed [ZW-1:0] z_off;
	always_comb begin
		if (z_s[N] > DEG90_Q16)
			z_cl = DEG90_Q16;
		else if (z_s[N] < -DEG90_Q16)
			z_cl = -DEG90_Q16;
		else
			z_cl = z_s[N];
		z_off = z_cl + DEG90_Q16;
	end

	// reciprocal of 45 is exact for every quotient input below 2^20
	logic [WW-1:0] w_div;
	assign w_div = m_s2[MW-1:DIV_PRE];

	logic [PW-1:0]  pos;
	logic [IW-1:0]  idx;
	logic [7:0]     frac;
	logic [8:0]     inv_frac;
	logic [16:0]    prod_lo, prod_hi;
	logic           single;
	out_t           res;

	always_comb begin
		pos      = p_s3[RSHIFT+PW-1:RSHIFT];
		idx      = pos[PW-1:8];
		frac     = pos[7:0];
		inv_frac = 9'd256 - {1'b0, frac};
		prod_lo  = 17'(inv_frac) * 17'(max_level_q);
		prod_hi  = 17'(frac) * 17'(max_level_q);
		single   = (frac == 8'd0);
		res.first_motor   = 3'(idx);
		res.single_target = single;
		if (single) begin
			res.first_level  = max_level_q;
			res.second_motor = 3'(idx);
			res.second_level = 8'd0;
		end else begin
			res.first_level  = prod_lo[15:8];
			res.second_motor = 3'(idx) + 3'd1;
			res.second_level = prod_hi[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_s[N];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= UW'(unsigned'(z_off));
			m_s2   <= MW'(u_s1) * MW'(MOTOR_COUNT - 1);
			p_s3   <= PRW'(w_div) * PRW'(RECIP45);
			out_s4 <= res;
		end
	end

	// skid: holds the final stage's request when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready)
				skid_full_q <= 1'b0;
		end else if (vld_s4 && !out_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q)
			skid_q <= out_s4;
	end

	assign out_valid = skid_full_q | vld_s4;
	assign out_data  = skid_full_q ? skid_q : out_s4;

	// a lone target repeats the motor and drives nothing on the second one
	a_single_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.single_target |->
			out_data.second_level == 8'd0 && out_data.second_motor == out_data.first_motor)
		else $error("single target result has a second motor level");

	// rotations keep x positive; a sign flip means the datapath overflowed
	a_x_positive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N] && !byp_s[N] |-> x_s[N] > 0)
		else $error("CORDIC x went non-positive");

	// a full skid freezes the pipeline so nothing behind it is lost
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !out_ready |=> skid_full_q && $stable(out_s4) && $stable(vld_s4))
		else $error("pipeline moved while skid was full");

	a_skid_visible: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !out_ready && !skid_full_q |=> out_valid && out_data == $past(out_s4))
		else $error("stalled result not presented from skid");

endmodule

/* bench/pan_checker.sv */
// Watches the request, result and config channels of the panning block, predicts each result and compares it.
module pan_checker #(
	parameter int MOTOR_COUNT  = 8,
	parameter int CORDIC_STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  dmpp_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  dmpp_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	output int             fail_count,
	output int             outstanding,
	output int             checked,
	output int             single_hits
);
	timeunit 1ns;
	timeprecision 1ps;
	import dmpp_pkg::*;

	localparam longint DEG_Q16 = 65536;
	localparam longint RIGHT_ANGLE = 90 * DEG_Q16;
	localparam int MAX_REPORTS = 10;

	// atan(2^-i) in degrees, Q16
	longint rot_angle [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic [7:0] level;
	out_t       expected_pan [$];
	out_t       want;
	int         failures;

	assign fail_count = failures;

	function automatic longint heading_q16(input logic signed [15:0] fx,
					       input logic signed [15:0] fy);
		longint x, y, z, xs, ys;
		x = fx;
		y = fy;
		z = 0;
		if (x <= 0) begin
			// on or behind the lateral axis: pin to a side, the origin to straight ahead
			if (y < 0)
				z = -RIGHT_ANGLE;
			else if (!(y == 0 && x == 0))
				z = RIGHT_ANGLE;
		end else if (y != 0) begin
			x = x * 256;
			y = y * 256;
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + rot_angle[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - rot_angle[i];
				end
			end
		end
		return z;
	endfunction

	function automatic out_t pan_predict(input in_t v, input logic [7:0] lvl);
		longint z;
		longint unsigned pos, idx, frac, full;
		out_t r;
		z = heading_q16(v.vec_x, v.vec_y);
		if (z > RIGHT_ANGLE)
			z = RIGHT_ANGLE;
		if (z < -RIGHT_ANGLE)
			z = -RIGHT_ANGLE;
		full = lvl;
		pos = (longint'(z + RIGHT_ANGLE) * (MOTOR_COUNT - 1) * 256) / (180 * DEG_Q16);
		idx = pos >> 8;
		frac = pos & 64'hFF;
		r.first_motor = 3'(idx);
		if (frac == 0) begin
			r.first_level = lvl;
			r.second_motor = 3'(idx);
			r.second_level = '0;
			r.single_target = 1'b1;
		end else begin
			r.first_level = 8'(((256 - frac) * full) >> 8);
			r.second_motor = 3'(idx + 1);
			r.second_level = 8'((frac * full) >> 8);
			r.single_target = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level <= 8'd255;
			expected_pan.delete();
			outstanding <= 0;
		end else begin
			// retire before push so an unexpected result never takes a fresh request
			if (out_valid && out_ready) begin
				if (expected_pan.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("%0t: result with nothing pending: %p", $realtime, out_data);
				end else begin
					want = expected_pan.pop_front();
					checked++;
					if (want.single_target)
						single_hits++;
					if (out_data.first_motor !== want.first_motor ||
					    out_data.first_level !== want.first_level ||
					    out_data.second_motor !== want.second_motor ||
					    out_data.second_level !== want.second_level ||
					    out_data.single_target !== want.single_target) begin
						failures++;
						if (failures <= MAX_REPORTS)
							$display({"%0t: pan mismatch exp m%0d/%0d m%0d/%0d s%0b",
								  " got m%0d/%0d m%0d/%0d s%0b"},
								 $realtime, want.first_motor, want.first_level,
								 want.second_motor, want.second_level, want.single_target,
								 out_data.first_motor, out_data.first_level,
								 out_data.second_motor, out_data.second_level,
								 out_data.single_target);
					end
				end
			end
			if (in_valid && in_ready)
				expected_pan.push_back(pan_predict(in_data, level));
			if (cfg_we)
				level <= cfg_wdata;
			outstanding <= expected_pan.size();
		end
	end

endmodule

/* bench/tb_top.sv */
// Top of the panning block bench: clock, reset, request stimulus, sink and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dmpp_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 158;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	logic [7:0] cfg_wdata;
	in_t  in_data;
	out_t out_data;

	int fail_count, outstanding, checked, single_hits;
	int vectors_sent = 0;
	int settings_used = 0;
	bit brisk_mode = 1'b0;
	bit hold_sink = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	direction_to_motor_pair_panning #(
		.MOTOR_COUNT(8),
		.CORDIC_STEPS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	pan_checker #(
		.MOTOR_COUNT(8),
		.CORDIC_STEPS(16)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked(checked),
		.single_hits(single_hits)
	);

	// returns at the edge that takes the request, valid still high
	task automatic push_vector(input logic signed [15:0] x, input logic signed [15:0] y);
		int gap;
		in_t v;
		gap = brisk_mode ? 0 : $urandom_range(0, 4);
		v.vec_x = x;
		v.vec_y = y;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		vectors_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_level(input logic [7:0] lvl);
		cfg_we <= 1'b1;
		cfg_wdata <= lvl;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic push_random();
		int kind;
		logic signed [15:0] x, y;
		kind = $urandom_range(0, 9);
		x = 16'($urandom);
		y = 16'($urandom);
		case (kind)
			0, 1, 2, 3, 4: x = 16'($urandom_range(1, 32767));
			5: begin
				x = 16'(int'($urandom_range(0, 16)) - 8);
				y = 16'(int'($urandom_range(0, 16)) - 8);
			end
			6: x = 16'(-int'($urandom_range(0, 32768)));
			7: y = 16'(int'($urandom_range(0, 2)) - 1);
			9: x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: ;
		endcase
		push_vector(x, y);
	endtask

	initial begin : sink
		int wait_cycles;
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_sink && !held) begin
				// long back-pressure so the pipeline fills and in_ready drops
				held = 1'b1;
				wait_cycles = LONG_HOLD;
			end else if (brisk_mode) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 4);
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid)
				@(negedge clk);
			@(posedge clk);
		end
	end

	initial begin : watchdog
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] lvl;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axes, corners, origin, behind-the-axis cases, near-exact positions
		push_vector(16'sd0, 16'sd0);
		push_vector(16'sd1, 16'sd0);
		push_vector(16'sd32767, 16'sd0);
		push_vector(16'sd0, 16'sd1);
		push_vector(16'sd0, -16'sd1);
		push_vector(-16'sd1, 16'sd0);
		push_vector(16'sh8000, 16'sd0);
		push_vector(16'sh8000, 16'sd32767);
		push_vector(16'sh8000, 16'sh8000);
		push_vector(16'sd0, 16'sd32767);
		push_vector(16'sd0, 16'sh8000);
		push_vector(16'sd32767, 16'sd32767);
		push_vector(16'sd32767, 16'sh8000);
		push_vector(16'sd1, 16'sd32767);
		push_vector(16'sd1, 16'sh8000);
		push_vector(16'sd32767, 16'sd1);
		push_vector(16'sd32767, -16'sd1);
		push_vector(16'sd1, 16'sd1);
		push_vector(16'sd10000, -16'sd20721);
		push_vector(16'sd10000, 16'sd7996);
		push_vector(16'sd100, -16'sd173);
		push_vector(-16'sd5, -16'sd5);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: lvl = 8'd0;
				1: lvl = 8'd255;
				2: lvl = 8'd1;
				3: lvl = 8'd170;
				default: lvl = 8'($urandom_range(0, 255));
			endcase
			set_max_level(lvl);
			brisk_mode = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 20)
					hold_sink = 1'b1;
				push_random();
			end
			drain();
			brisk_mode = 1'b0;
		end

		$display("Sent %0d direction vectors under %0d max_level writes plus the reset value.",
			 vectors_sent, settings_used);
		$display("Compared %0d results, %0d on a single motor; one long sink stall applied.",
			 checked, single_hits);
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* direction_to_motor_pair_panning.f */
src/dmpp_pkg.sv
src/direction_to_motor_pair_panning.sv
bench/pan_checker.sv
bench/tb_top.sv
